// File: hdl/at_command_guard_filter_core_assert.svh
// Assertion macros shared by the command guard filter RTL.
`ifndef AT_COMMAND_GUARD_FILTER_CORE_ASSERT_SVH
`define AT_COMMAND_GUARD_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACGF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACGF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/acgf_pkg.sv
// Types, codes and character helpers of the command guard filter.
package acgf_pkg;

    localparam int C_LEN_W = 7;

    localparam logic [1:0] V_PASS    = 2'd0;
    localparam logic [1:0] V_REWRITE = 2'd1;
    localparam logic [1:0] V_BLOCK   = 2'd2;

    localparam logic [7:0] C_SEMI    = ";";
    localparam logic [7:0] C_CH_P    = "P";
    localparam logic [7:0] C_CH_ZERO = "0";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] verdict;
        logic       too_long;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       store;
        logic       drop;
    } t_q_item;

    typedef struct packed {
        logic               loading;
        logic [C_LEN_W-1:0] fill;
    } t_back_status;

    function automatic logic [7:0] f_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic f_is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic f_is_blank(input logic [7:0] c);
        return c == " " || c == 8'h09;
    endfunction

    function automatic logic f_is_delim(input logic [7:0] c);
        return c == 8'h0d || c == 8'h0a || c == " " || c == 8'h09 || c == C_SEMI;
    endfunction

    // Lower-case letters of the word WBR.
    function automatic logic [7:0] f_wbr_char(input logic [2:0] n);
        unique case (n)
            3'd0:    return "w";
            3'd1:    return "b";
            3'd2:    return "r";
            default: return 8'h00;
        endcase
    endfunction

    // Lower-case letters of the word SAVCAL.
    function automatic logic [7:0] f_savcal_char(input logic [2:0] n);
        unique case (n)
            3'd0:    return "s";
            3'd1:    return "a";
            3'd2:    return "v";
            3'd3:    return "c";
            3'd4:    return "a";
            3'd5:    return "l";
            default: return 8'h00;
        endcase
    endfunction

endpackage

// File: hdl/at_command_guard_filter_core.sv
// Top level of the command guard filter: front, queue, back and control register.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------
//  in       | i_in_valid / o_in_stall      | i_in_data  (t_in_item)
//  out      | o_out_valid / i_out_stall    | o_out_data (t_out_item)
//  cfg      | i_cfg_valid / o_cfg_ready    | i_cfg_data (rewrite enable)
//
// Bytes are taken one per cycle while the two-entry queue has room.
// After the last byte the scan sequencer walks the buffer through its single read port,
// reading each scanned position and each letter or blank after a command start, and
// writing four bytes for each patched command.
// Emission then sends one byte at a time, holding each byte while the output is stalled.
// Reset clears the fill count, the overflow flag and sets rewriting on.
module at_command_guard_filter_core #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  acgf_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output acgf_pkg::t_out_item o_out_data,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_data,
    output logic                o_cfg_ready
);

    `include "at_command_guard_filter_core_assert.svh"

    logic                   r_rewrite_en;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_q_full;
    logic                   w_q_empty;
    acgf_pkg::t_q_item      w_front_item;
    acgf_pkg::t_q_item      w_q_item;
    acgf_pkg::t_back_status w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rewrite_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_rewrite_en <= i_cfg_data;
        end
    end

    acgf_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_q_item   (w_front_item)
    );

    acgf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    acgf_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rewrite_en (r_rewrite_en),
        .i_q_empty    (w_q_empty),
        .i_q_item     (w_q_item),
        .o_pop        (w_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_data),
        .o_status     (w_status)
    );

    `ACGF_ASSERT_IMPL(a_no_output_while_loading, i_clk, i_rst_n, w_status.loading, !o_out_valid, "output valid during loading")
    `ACGF_ASSERT_NEXT(a_load_after_last, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_out_data.out_last, w_status.loading && w_status.fill == '0, "buffer not released after last item")
    `ACGF_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, w_status.fill <= BUF_DEPTH, "fill count beyond buffer depth")

endmodule

// File: hdl/acgf_queue.sv
// Two-entry queue of classified items between the front and the back.
module acgf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  acgf_pkg::t_q_item i_item,
    input  logic              i_pop,
    output acgf_pkg::t_q_item o_item,
    output logic              o_full,
    output logic              o_empty
);

    acgf_pkg::t_q_item r_slot [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// File: hdl/acgf_front.sv
// Input side: accepts bytes and marks each one as stored or dropped.
module acgf_front #(
    parameter int BUF_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  acgf_pkg::t_in_item i_in_item,
    output logic               o_in_stall,
    input  logic               i_q_full,
    output logic               o_push,
    output acgf_pkg::t_q_item  o_q_item
);

    localparam int LW = $clog2(BUF_DEPTH + 1);

    logic [LW-1:0] r_cnt;
    logic          w_store;

    assign w_store    = r_cnt < LW'(BUF_DEPTH);
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign o_q_item.data_byte = i_in_item.data_byte;
    assign o_q_item.last_byte = i_in_item.last_byte;
    assign o_q_item.store     = w_store;
    assign o_q_item.drop      = !w_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            if (i_in_item.last_byte) begin
                r_cnt <= '0;
            end else if (w_store) begin
                r_cnt <= r_cnt + LW'(1);
            end
        end
    end

endmodule

// File: hdl/acgf_back.sv
// Back side: chunk buffer, command scan sequencer and byte emitter.
module acgf_back #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rewrite_en,
    input  logic                   i_q_empty,
    input  acgf_pkg::t_q_item      i_q_item,
    output logic                   o_pop,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output acgf_pkg::t_out_item    o_out_item,
    output acgf_pkg::t_back_status o_status
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int LW = $clog2(BUF_DEPTH + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_LOOP, S_C0, S_C1, S_CHK, S_SK_RD, S_SK_CHK,
        S_W_RD, S_W_CHK, S_PATCH, S_E_RD, S_E_LD, S_E_WAIT
    } t_state;

    typedef enum logic [1:0] {PH_J, PH_K, PH_M} t_phase;

    logic [7:0]          mem [BUF_DEPTH];
    logic [7:0]          r_rd;

    t_state              r_state;
    t_phase              r_phase;
    logic [LW-1:0]       r_len;
    logic                r_ovf;
    logic [LW-1:0]       r_i;
    logic [LW-1:0]       r_j;
    logic [LW-1:0]       r_k;
    logic [LW-1:0]       r_p;
    logic [LW-1:0]       r_n;
    logic [2:0]          r_wn;
    logic                r_mw;
    logic                r_ms;
    logic                r_is_st;
    logic                r_delim;
    logic [7:0]          r_c0;
    logic [7:0]          r_l1;
    logic [7:0]          r_l3;
    logic [7:0]          r_l4;
    logic [1:0]          r_pc;
    logic [1:0]          r_verdict;
    logic                r_out_valid;
    acgf_pkg::t_out_item r_out;

    logic [AW-1:0]       w_ra;
    logic                w_we;
    logic [AW-1:0]       w_wa;
    logic [7:0]          w_wd;
    logic [LW-1:0]       w_i1;
    logic [LW-1:0]       w_n1;
    logic                w_end;
    logic [7:0]          w_lc;
    logic [7:0]          w_c;
    logic                w_more;
    logic                w_wblk;
    logic                w_mw;
    logic                w_ms;
    logic [7:0]          w_c0l;
    logic                w_at;
    logic                w_st;

    assign w_i1   = r_i + LW'(1);
    assign w_n1   = r_n + LW'(1);
    assign w_end  = r_p >= r_len;
    assign w_lc   = acgf_pkg::f_lower(r_rd);
    assign w_c    = w_end ? 8'h00 : w_lc;
    assign w_more = ({1'b0, r_i} + (LW + 1)'(1)) < {1'b0, r_len};
    assign w_c0l  = acgf_pkg::f_lower(r_c0);
    assign w_at   = w_c0l == "a" && w_lc == "t";
    assign w_st   = w_c0l == "s" && w_lc == "t";
    assign o_pop  = (r_state == S_LOAD) && !i_q_empty;

    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;
    assign o_status.loading = r_state == S_LOAD;
    assign o_status.fill    = (acgf_pkg::C_LEN_W)'(r_len);

    always_comb begin
        w_wblk = ((r_wn == 3'd3) && r_mw && (w_end || !acgf_pkg::f_is_letter(r_rd))) ||
                 ((r_wn == 3'd6) && r_ms && (w_end || !acgf_pkg::f_is_letter(r_rd)));
        w_mw   = (r_wn < 3'd3) && r_mw && !w_end && (w_lc == acgf_pkg::f_wbr_char(r_wn));
        w_ms   = (r_wn < 3'd6) && r_ms && !w_end && (w_lc == acgf_pkg::f_savcal_char(r_wn));
    end

    always_comb begin
        w_ra = r_p[AW-1:0];
        w_we = 1'b0;
        w_wa = r_len[AW-1:0];
        w_wd = i_q_item.data_byte;
        unique case (r_state)
            S_LOAD: begin
                w_we = o_pop && i_q_item.store;
            end
            S_C0:     w_ra = r_i[AW-1:0];
            S_C1:     w_ra = w_i1[AW-1:0];
            S_PATCH: begin
                w_we = 1'b1;
                unique case (r_pc)
                    2'd0: begin
                        w_wa = r_i[AW-1:0];
                        w_wd = "A";
                    end
                    2'd1: begin
                        w_wa = w_i1[AW-1:0];
                        w_wd = "T";
                    end
                    2'd2: begin
                        w_wa = r_j[AW-1:0];
                        w_wd = r_l3;
                    end
                    default: begin
                        w_wa = r_k[AW-1:0];
                        w_wd = r_l4;
                    end
                endcase
            end
            S_E_RD:   w_ra = r_n[AW-1:0];
            S_E_WAIT: w_ra = w_n1[AW-1:0];
            default:  w_ra = r_p[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd <= mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (o_pop) begin
                        if (i_q_item.store) begin
                            r_len <= r_len + LW'(1);
                        end
                        if (i_q_item.drop) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_q_item.last_byte) begin
                            r_i       <= '0;
                            r_delim   <= 1'b1;
                            r_verdict <= acgf_pkg::V_PASS;
                            r_state   <= S_LOOP;
                        end
                    end
                end
                S_LOOP: begin
                    if (w_more) begin
                        r_state <= S_C0;
                    end else begin
                        r_n     <= '0;
                        r_state <= S_E_RD;
                    end
                end
                S_C0: r_state <= S_C1;
                S_C1: begin
                    r_c0    <= r_rd;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if ((w_at || w_st) && r_delim) begin
                        r_is_st <= w_st;
                        r_delim <= 1'b0;
                        r_p     <= r_i + LW'(2);
                        r_phase <= PH_J;
                        r_state <= S_SK_RD;
                    end else begin
                        r_delim <= acgf_pkg::f_is_delim(r_c0);
                        r_i     <= w_i1;
                        r_state <= S_LOOP;
                    end
                end
                S_SK_RD: r_state <= S_SK_CHK;
                S_SK_CHK: begin
                    if (!w_end && acgf_pkg::f_is_blank(r_rd)) begin
                        r_p     <= r_p + LW'(1);
                        r_state <= S_SK_RD;
                    end else begin
                        unique case (r_phase)
                            PH_J: begin
                                if (w_end) begin
                                    r_n     <= '0;
                                    r_state <= S_E_RD;
                                end else begin
                                    r_j  <= r_p;
                                    r_l1 <= w_c;
                                    if (r_is_st) begin
                                        r_wn    <= 3'd0;
                                        r_mw    <= 1'b1;
                                        r_ms    <= 1'b1;
                                        r_state <= S_W_RD;
                                    end else begin
                                        r_p     <= r_p + LW'(1);
                                        r_phase <= PH_K;
                                        r_state <= S_SK_RD;
                                    end
                                end
                            end
                            PH_K: begin
                                r_k <= r_p;
                                if ((r_l1 == "s" && w_c == "p") ||
                                    (r_l1 == "m" && w_c == "1")) begin
                                    r_verdict <= acgf_pkg::V_REWRITE;
                                    if (i_rewrite_en) begin
                                        r_l3    <= (r_l1 == "s") ? "T" : "M";
                                        r_l4    <= (r_l1 == "s") ? acgf_pkg::C_CH_P
                                                                 : acgf_pkg::C_CH_ZERO;
                                        r_pc    <= 2'd0;
                                        r_state <= S_PATCH;
                                    end else begin
                                        r_i     <= r_p + LW'(1);
                                        r_state <= S_LOOP;
                                    end
                                end else if (r_l1 == "p" && w_c == "p") begin
                                    r_p     <= r_p + LW'(1);
                                    r_phase <= PH_M;
                                    r_state <= S_SK_RD;
                                end else if ((r_l1 == "s" && w_c == "d") ||
                                             (r_l1 == "c" && w_c == "v")) begin
                                    r_verdict <= acgf_pkg::V_BLOCK;
                                    r_n       <= '0;
                                    r_state   <= S_E_RD;
                                end else begin
                                    r_i     <= w_i1;
                                    r_state <= S_LOOP;
                                end
                            end
                            default: begin
                                if (w_c == "s") begin
                                    r_i     <= r_p + LW'(1);
                                    r_state <= S_LOOP;
                                end else begin
                                    r_verdict <= acgf_pkg::V_BLOCK;
                                    r_n       <= '0;
                                    r_state   <= S_E_RD;
                                end
                            end
                        endcase
                    end
                end
                S_W_RD: r_state <= S_W_CHK;
                S_W_CHK: begin
                    if (w_wblk) begin
                        r_verdict <= acgf_pkg::V_BLOCK;
                        r_n       <= '0;
                        r_state   <= S_E_RD;
                    end else if (!w_mw && !w_ms) begin
                        r_i     <= w_i1;
                        r_state <= S_LOOP;
                    end else begin
                        r_mw <= w_mw;
                        r_ms <= w_ms;
                        r_wn <= r_wn + 3'd1;
                        if (!w_end) begin
                            r_p <= r_p + LW'(1);
                        end
                        r_state <= S_W_RD;
                    end
                end
                S_PATCH: begin
                    r_pc <= r_pc + 2'd1;
                    if (r_pc == 2'd3) begin
                        r_i     <= r_k + LW'(1);
                        r_state <= S_LOOP;
                    end
                end
                S_E_RD: r_state <= S_E_LD;
                S_E_LD: begin
                    r_out.out_byte <= r_rd;
                    r_out.out_last <= w_n1 == r_len;
                    r_out.verdict  <= r_verdict;
                    r_out.too_long <= r_ovf;
                    r_out_valid    <= 1'b1;
                    r_state        <= S_E_WAIT;
                end
                S_E_WAIT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out.out_last) begin
                            r_len   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_n     <= w_n1;
                            r_state <= S_E_LD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule
